[rtl/core/esc_pkg.sv]
// Package for the environmental sensor compensation pipeline.
// Holds register indexes, widths and the pipeline payload types; no dependencies.
`timescale 1ns / 1ps
package esc_pkg;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 64;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TEMP       = 3'd0,
    CFG_PRESS_A    = 3'd1,
    CFG_PRESS_B    = 3'd2,
    CFG_PRESS_NINE = 3'd3,
    CFG_HUM        = 3'd4
  } cfg_idx_e;

  localparam int unsigned DivW = 32;

  // dividend / divisor pair handed to the divider
  typedef struct packed {
    logic [31:0] num;
    logic [31:0] den;
    logic        hi;   // dividend had its top bit set: divide first, double after
    logic        zero; // divisor is zero
  } div_req_t;

  // arithmetic right shift of a 32-bit pattern
  function automatic logic [31:0] asr32(input logic [31:0] x, input int unsigned n);
    asr32 = 32'($signed(x) >>> n);
  endfunction

endpackage

[rtl/core/env_sensor_compensation.sv]
// Environmental sensor compensation pipeline, top level.
// Stages: 13 front-end, 32 divider and 4 output stages from input transfer to result.
// Throughput: one sample per cycle; the whole pipeline holds on output stall.
// Reset: valid bits and calibration registers clear to zero; payload not reset.
// Depends on esc_pkg, esc_div, esc_delay.
`timescale 1ns / 1ps
module env_sensor_compensation
  import esc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CfgIdxW-1:0]   cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [19:0]          raw_temp_i,
  input  logic [19:0]          raw_press_i,
  input  logic [15:0]          raw_hum_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic signed [31:0]   temp_centi_o,
  output logic [31:0]          press_pa_o,
  output logic [16:0]          hum_q10_o
);

  localparam int unsigned NPre = 14;
  localparam int unsigned NTot = NPre + DivW + 3;

  logic [47:0] cal_temp_q;
  logic [63:0] cal_pa_q, cal_pb_q, cal_hum_q;
  logic [15:0] cal_p9_q;

  // write calibration registers
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_temp_q <= '0; cal_pa_q <= '0; cal_pb_q <= '0; cal_p9_q <= '0; cal_hum_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_TEMP:       cal_temp_q <= cfg_data_i[47:0];
        CFG_PRESS_A:    cal_pa_q <= cfg_data_i;
        CFG_PRESS_B:    cal_pb_q <= cfg_data_i;
        CFG_PRESS_NINE: cal_p9_q <= cfg_data_i[15:0];
        CFG_HUM:        cal_hum_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // calibration words extended to 32 bits
  logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9, h1, h2, h3, h4, h5, h6;
  assign t1 = {16'd0, cal_temp_q[15:0]};
  assign t2 = {{16{cal_temp_q[31]}}, cal_temp_q[31:16]};
  assign t3 = {{16{cal_temp_q[47]}}, cal_temp_q[47:32]};
  assign p1 = {16'd0, cal_pa_q[15:0]};
  assign p2 = {{16{cal_pa_q[31]}}, cal_pa_q[31:16]};
  assign p3 = {{16{cal_pa_q[47]}}, cal_pa_q[47:32]};
  assign p4 = {{16{cal_pa_q[63]}}, cal_pa_q[63:48]};
  assign p5 = {{16{cal_pb_q[15]}}, cal_pb_q[15:0]};
  assign p6 = {{16{cal_pb_q[31]}}, cal_pb_q[31:16]};
  assign p7 = {{16{cal_pb_q[47]}}, cal_pb_q[47:32]};
  assign p8 = {{16{cal_pb_q[63]}}, cal_pb_q[63:48]};
  assign p9 = {{16{cal_p9_q[15]}}, cal_p9_q};
  assign h1 = {24'd0, cal_hum_q[7:0]};
  assign h2 = {{16{cal_hum_q[23]}}, cal_hum_q[23:8]};
  assign h3 = {24'd0, cal_hum_q[31:24]};
  assign h4 = {{20{cal_hum_q[43]}}, cal_hum_q[43:32]};
  assign h5 = {{20{cal_hum_q[55]}}, cal_hum_q[55:44]};
  assign h6 = {{24{cal_hum_q[63]}}, cal_hum_q[63:56]};

  // pipeline enable: advance when output slot is free or empty
  logic [NTot-1:0] vld_q;
  logic en;
  assign en = !vld_q[NTot-1] || out_ready_i;
  assign in_ready_o = en;
  assign out_valid_o = vld_q[NTot-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NTot-2:0], in_valid_i};
    end
  end

  // stage registers (a stage may hold several multiplies)
  logic [31:0] s1_a_q, s1_d_q, s1_p_q, s1_h_q;
  logic [31:0] s2_v1_q, s2_dd_q, s2_p_q, s2_h_q;
  logic [31:0] s3_v1_q, s3_v2_q, s3_p_q, s3_h_q;
  logic [31:0] s4_f_q, s4_p_q, s4_h_q;
  logic [31:0] s5_f_q, s5_t_q, s5_pv1_q, s5_d_q, s5_p_q, s5_h_q, s5_hh_q;
  logic [31:0] s6_t_q, s6_pv1_q, s6_dd_q, s6_p_q, s6_v15_q, s6_p2v_q, s6_hh_q;
  logic [31:0] s6_h5_q, s6_b_q, s6_c_q, s6_hin_q;
  logic [31:0] s7_t_q, s7_p_q, s7_v2a_q, s7_v2b_q, s7_p3_q, s7_p2_q, s7_a_q, s7_e_q;
  logic [31:0] s8_t_q, s8_p_q, s8_v2_q, s8_x_q, s8_a_q, s8_f_q;
  logic [31:0] s9_t_q, s9_p_q, s9_v2_q, s9_x_q, s9_a_q, s9_f_q;
  logic [31:0] s10_t_q, s10_p_q, s10_v2_q, s10_y_q, s10_h_q;
  logic [31:0] s11_t_q, s11_num_q, s11_den_q, s11_h_q;
  logic [31:0] s12_t_q, s12_num_q, s12_den_q, s12_h_q;
  logic [31:0] s13_d2_q, s13_h_q;
  logic [31:0] s14_h_q;
  logic [31:0] s13_t_q, s13_num_q, s13_den_q;
  logic        s13_hi_q, s13_z_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      // 1: temperature operands; pressure and humidity registered
      s1_a_q <= {15'd0, raw_temp_i[19:3]} - {t1[30:0], 1'b0};
      s1_d_q <= {16'd0, raw_temp_i[19:4]} - t1;
      s1_p_q <= {12'd0, raw_press_i};
      s1_h_q <= {16'd0, raw_hum_i};
      // 2
      s2_v1_q <= asr32(s1_a_q * t2, 11);
      s2_dd_q <= asr32(s1_d_q * s1_d_q, 12);
      s2_p_q <= s1_p_q; s2_h_q <= s1_h_q;
      // 3
      s3_v1_q <= s2_v1_q;
      s3_v2_q <= asr32(s2_dd_q * t3, 14);
      s3_p_q <= s2_p_q; s3_h_q <= s2_h_q;
      // 4: fine value
      s4_f_q <= s3_v1_q + s3_v2_q;
      s4_p_q <= s3_p_q; s4_h_q <= s3_h_q;
      // 5
      s5_f_q <= s4_f_q;
      s5_t_q <= asr32(s4_f_q * 32'd5 + 32'd128, 8);
      s5_pv1_q <= asr32(s4_f_q, 1) - 32'd64000;
      s5_d_q <= asr32(asr32(s4_f_q, 1) - 32'd64000, 2);
      s5_hh_q <= s4_f_q - 32'd76800;
      s5_p_q <= s4_p_q; s5_h_q <= s4_h_q;
      // 6
      s6_t_q <= s5_t_q; s6_pv1_q <= s5_pv1_q; s6_p_q <= s5_p_q;
      s6_dd_q <= s5_d_q * s5_d_q;
      s6_v15_q <= s5_pv1_q * p5;
      s6_p2v_q <= p2 * s5_pv1_q;
      s6_hh_q <= s5_hh_q;
      s6_h5_q <= h5 * s5_hh_q;
      s6_b_q <= asr32(s5_hh_q * h6, 10);
      s6_c_q <= asr32(s5_hh_q * h3, 11) + 32'd32768;
      s6_hin_q <= s5_h_q;
      // 7
      s7_t_q <= s6_t_q; s7_p_q <= s6_p_q;
      s7_v2a_q <= asr32(s6_dd_q, 11) * p6;
      s7_v2b_q <= {s6_v15_q[30:0], 1'b0};
      s7_p3_q <= p3 * asr32(s6_dd_q, 13);
      s7_p2_q <= s6_p2v_q;
      s7_a_q <= asr32(({s6_hin_q[17:0], 14'd0} - {h4[11:0], 20'd0} - s6_h5_q)
                + 32'd16384, 15);
      s7_e_q <= asr32(s6_b_q * s6_c_q, 10) + 32'd2097152;
      // 8
      s8_t_q <= s7_t_q; s8_p_q <= s7_p_q;
      s8_v2_q <= asr32(s7_v2a_q + s7_v2b_q, 2) + {p4[15:0], 16'd0};
      s8_x_q <= asr32(asr32(s7_p3_q, 3) + asr32(s7_p2_q, 1), 18);
      s8_a_q <= s7_a_q;
      s8_f_q <= asr32(s7_e_q * h2 + 32'd8192, 14);
      // 9
      s9_t_q <= s8_t_q; s9_p_q <= s8_p_q; s9_v2_q <= s8_v2_q;
      s9_x_q <= asr32((32'd32768 + s8_x_q) * p1, 15);
      s9_a_q <= s8_a_q; s9_f_q <= s8_f_q;
      // 10
      s10_t_q <= s9_t_q; s10_p_q <= s9_p_q; s10_v2_q <= s9_x_q;
      s10_y_q <= ((32'd1048576 - s9_p_q) - asr32(s9_v2_q, 12)) * 32'd3125;
      s10_h_q <= s9_a_q * s9_f_q;
      // 11
      s11_t_q <= s10_t_q; s11_den_q <= s10_v2_q; s11_num_q <= s10_y_q;
      s11_h_q <= s10_h_q;
      // 12: humidity square term
      s12_t_q <= s11_t_q; s12_den_q <= s11_den_q; s12_num_q <= s11_num_q;
      s12_h_q <= s11_h_q;
      s13_d2_q <= asr32(asr32(s11_h_q, 15) * asr32(s11_h_q, 15), 7);
      // 13: divider request
      s13_t_q <= s12_t_q; s13_den_q <= s12_den_q;
      s13_hi_q <= s12_num_q[31];
      s13_z_q <= (s12_den_q == 32'd0);
      s13_num_q <= s12_num_q[31] ? s12_num_q : {s12_num_q[30:0], 1'b0};
      s13_h_q <= s12_h_q - asr32(s13_d2_q * h1, 4);
      // 14: clamp humidity
      if (s13_h_q[31]) s14_h_q <= '0;
      else if (s13_h_q > 32'd419430400) s14_h_q <= 32'd419430400;
      else s14_h_q <= s13_h_q;
    end
  end

  // divider and matching payload delay
  logic [31:0] quo;
  esc_div u_div (
    .clk_i(clk_i), .rst_ni(rst_ni), .en_i(en),
    .num_i(s13_num_q), .den_i(s13_den_q), .quo_o(quo)
  );

  logic [80:0] dly_in, dly_out;
  assign dly_in = {s13_hi_q, s13_z_q, s13_t_q, 30'd0, s14_h_q[28:12]};
  logic [31:0] t_hold_q;
  logic hi_hold_q, z_hold_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      t_hold_q <= s13_t_q; hi_hold_q <= s13_hi_q; z_hold_q <= s13_z_q;
    end
  end
  // humidity is one stage behind the rest; realign through the hold registers
  logic [80:0] dly_d;
  assign dly_d = {hi_hold_q, z_hold_q, t_hold_q, 30'd0, s14_h_q[28:12]};
  esc_delay u_dly (.clk_i(clk_i), .en_i(en), .d_i(dly_d), .q_o(dly_out));

  logic [31:0] quo_q;
  always_ff @(posedge clk_i) if (en) quo_q <= quo;

  // final pressure correction, three stages
  logic [31:0] pq, sq_q, r1_q, r2_q, r2b_q, pc_q, pc2_q, pfin_q;
  logic [31:0] tf_q, tf2_q, tout_q;
  logic [16:0] hf_q, hf2_q, hout_q;
  logic z_q, z2_q;
  assign pq = dly_out[80] ? {quo_q[30:0], 1'b0} : quo_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      // square of the quotient and the P8 term
      sq_q <= ({3'd0, pq[31:3]} * {3'd0, pq[31:3]}) >> 13;
      r2_q <= asr32({2'd0, pq[31:2]} * p8, 13);
      pc_q <= pq; z_q <= dly_out[79];
      tf_q <= dly_out[78:47]; hf_q <= dly_out[16:0];
      // P9 term
      r1_q <= p9 * sq_q;
      r2b_q <= r2_q; pc2_q <= pc_q; z2_q <= z_q;
      tf2_q <= tf_q; hf2_q <= hf_q;
      // sum the corrections
      pfin_q <= z2_q ? 32'd0 : pc2_q + asr32(asr32(r1_q, 12) + r2b_q + p7, 4);
      tout_q <= tf2_q; hout_q <= hf2_q;
    end
  end
  assign temp_centi_o = tout_q;
  assign press_pa_o = pfin_q;
  assign hum_q10_o = hout_q;

  logic unused;
  assign unused = ^{dly_in, dly_out[46:17], s2_p_q[0], s12_h_q[0],
                   s5_f_q, s6_pv1_q, s6_hh_q};

  // a stalled result must hold
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(press_pa_o))
    else $error("result changed under stall");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o) else $error("ready low with empty output");
  a_hum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> hum_q10_o <= 17'd102400) else $error("humidity out of range");

endmodule

[rtl/core/esc_div.sv]
// Pipelined unsigned 32/32 divider, one quotient bit per stage.
// Depends on esc_pkg; an item can enter every cycle, stalls freeze all stages.
`timescale 1ns / 1ps
module esc_div
  import esc_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic [31:0]   num_i,
  input  logic [31:0]   den_i,
  output logic [31:0]   quo_o
);

  logic [31:0] rem_q [DivW];
  logic [31:0] num_q [DivW];
  logic [31:0] den_q [DivW];
  logic [31:0] quo_q [DivW];

  // one restoring step: shift in the next dividend bit, subtract if it fits
  function automatic logic [32:0] div_step(input logic [31:0] rem, input logic nbit,
                                           input logic [31:0] den);
    logic [32:0] sh;
    logic [32:0] trial;
    sh = {rem, nbit};
    trial = sh - {1'b0, den};
    div_step = trial[32] ? {1'b0, sh[31:0]} : {1'b1, trial[31:0]};
  endfunction

  // advance every stage by one quotient bit
  always_ff @(posedge clk_i) begin
    logic [32:0] st;
    if (en_i) begin
      st = div_step(32'd0, num_i[31], den_i);
      rem_q[0] <= st[31:0];
      quo_q[0] <= {31'd0, st[32]};
      num_q[0] <= {num_i[30:0], 1'b0};
      den_q[0] <= den_i;
      for (int s = 1; s < DivW; s++) begin
        st = div_step(rem_q[s-1], num_q[s-1][31], den_q[s-1]);
        rem_q[s] <= st[31:0];
        quo_q[s] <= {quo_q[s-1][30:0], st[32]};
        num_q[s] <= {num_q[s-1][30:0], 1'b0};
        den_q[s] <= den_q[s-1];
      end
    end
  end

  assign quo_o = quo_q[DivW-1];

  logic unused_rst;
  assign unused_rst = rst_ni;

endmodule

[rtl/core/esc_delay.sv]
// Payload delay line matching the divider depth.
// Depends on esc_pkg; advances only when enabled.
`timescale 1ns / 1ps
module esc_delay
  import esc_pkg::*;
(
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [80:0]   d_i,
  output logic [80:0]   q_o
);

  logic [80:0] tap_q [DivW];

  // shift the tap chain
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tap_q[0] <= d_i;
      for (int i = 1; i < DivW; i++) tap_q[i] <= tap_q[i-1];
    end
  end

  assign q_o = tap_q[DivW-1];

endmodule
